// ===== src/jdwp_stream_deframer_top_defines.svh =====
// ----------------------------------------------------------------------------
// jdwp_stream_deframer_top_defines.svh
// Assertion macros shared by the deframer checker.
// ----------------------------------------------------------------------------
`ifndef JDWP_STREAM_DEFRAMER_TOP_DEFINES_SVH
`define JDWP_STREAM_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define JDWP_SD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define JDWP_SD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/jdwp_sd_pkg.sv =====
// ----------------------------------------------------------------------------
// jdwp_sd_pkg
// Shared types and constants of the JDWP stream deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jdwp_sd_pkg;

    // result kinds
    localparam logic [2:0] KIND_PENDING = 3'd0;
    localparam logic [2:0] KIND_HS_GOOD = 3'd1;
    localparam logic [2:0] KIND_HS_BAD  = 3'd2;
    localparam logic [2:0] KIND_HEADER  = 3'd3;
    localparam logic [2:0] KIND_PAYLOAD = 3'd4;
    localparam logic [2:0] KIND_BAD_PKT = 3'd5;

    localparam logic [3:0]  HS_LAST    = 4'd13;   // index of last handshake byte
    localparam logic [3:0]  HDR_LAST   = 4'd10;   // index of last header byte
    localparam logic [31:0] HDR_LEN    = 32'd11;
    localparam int          REPLY_BIT  = 7;
    localparam logic [7:0]  DDM_SET    = 8'hc7;
    localparam logic [7:0]  DDM_CMD    = 8'h01;
    localparam int          TDATA_W    = 112;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] packet_length;
        logic [31:0] packet_id;
        logic        is_reply;
        logic        is_error;
        logic [7:0]  cmd_set;
        logic [7:0]  cmd_code;
        logic [15:0] error_code;
        logic        is_ddm;
        logic [7:0]  payload_byte;
        logic        last_of_packet;
    } result_t;

    // "JDWP-Handshake"; indices past the end repeat the last character
    function automatic logic [7:0] hs_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h4a;  // J
            4'd1:    c = 8'h44;  // D
            4'd2:    c = 8'h57;  // W
            4'd3:    c = 8'h50;  // P
            4'd4:    c = 8'h2d;  // -
            4'd5:    c = 8'h48;  // H
            4'd6:    c = 8'h61;  // a
            4'd7:    c = 8'h6e;  // n
            4'd8:    c = 8'h64;  // d
            4'd9:    c = 8'h73;  // s
            4'd10:   c = 8'h68;  // h
            4'd11:   c = 8'h61;  // a
            4'd12:   c = 8'h6b;  // k
            default: c = 8'h65;  // e
        endcase
        return c;
    endfunction

endpackage

// ===== src/jdwp_sd_in_stage.sv =====
// ----------------------------------------------------------------------------
// jdwp_sd_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdwp_sd_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       advance,
    output logic       in_valid,
    output logic [7:0] in_byte
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // refill in the same cycle the held byte moves on
    assign s_tready   = !valid_reg || advance;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

// ===== src/jdwp_sd_parser.sv =====
// ----------------------------------------------------------------------------
// jdwp_sd_parser
// Per-byte state update: handshake match, header collection, payload count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdwp_sd_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic [7:0]            data_byte,
    output jdwp_sd_pkg::result_t  result
);
    import jdwp_sd_pkg::*;

    typedef enum logic [2:0] {
        PH_HANDSHAKE = 3'd0,
        PH_HEADER    = 3'd1,
        PH_PAYLOAD   = 3'd2,
        PH_HS_FAIL   = 3'd3,
        PH_PKT_FAIL  = 3'd4
    } phase_t;

    phase_t      phase_reg,    phase_next;
    logic [3:0]  count_reg,    count_next;
    logic        mismatch_reg, mismatch_next;
    logic [31:0] length_reg,   length_next;
    logic [31:0] id_reg,       id_next;
    logic [7:0]  flags_reg,    flags_next;
    logic [7:0]  set_reg,      set_next;
    logic [31:0] left_reg,     left_next;
    logic        hs_miss;

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        mismatch_next = mismatch_reg;
        length_next   = length_reg;
        id_next       = id_reg;
        flags_next    = flags_reg;
        set_next      = set_reg;
        left_next     = left_reg;
        result        = '0;
        hs_miss       = mismatch_reg || (data_byte != hs_char(count_reg));

        unique case (phase_reg)
            PH_HS_FAIL:
            begin
                result.kind = KIND_HS_BAD;
            end
            PH_PKT_FAIL:
            begin
                result.kind = KIND_BAD_PKT;
            end
            PH_HEADER:
            begin
                if (count_reg < 4'd4)
                begin
                    length_next = {length_reg[23:0], data_byte};
                end
                else if (count_reg < 4'd8)
                begin
                    id_next = {id_reg[23:0], data_byte};
                end
                else if (count_reg == 4'd8)
                begin
                    flags_next = data_byte;
                end
                else if (count_reg == 4'd9)
                begin
                    set_next = data_byte;
                end

                if (count_reg < HDR_LAST)
                begin
                    count_next  = count_reg + 4'd1;
                    result.kind = KIND_PENDING;
                end
                else
                begin
                    count_next = '0;
                    if (length_reg < HDR_LEN)
                    begin
                        phase_next  = PH_PKT_FAIL;
                        result.kind = KIND_BAD_PKT;
                    end
                    else
                    begin
                        result.kind          = KIND_HEADER;
                        result.packet_length = length_reg;
                        result.packet_id     = id_reg;
                        if (flags_reg[REPLY_BIT])
                        begin
                            // error code: byte 9 low, byte 10 high
                            result.is_reply   = 1'b1;
                            result.error_code = {data_byte, set_reg};
                            result.is_error   = |{data_byte, set_reg};
                        end
                        else
                        begin
                            result.cmd_set  = set_reg;
                            result.cmd_code = data_byte;
                            result.is_ddm   = (set_reg == DDM_SET) && (data_byte == DDM_CMD);
                        end
                        if (length_reg == HDR_LEN)
                        begin
                            result.last_of_packet = 1'b1;
                            phase_next            = PH_HEADER;
                        end
                        else
                        begin
                            left_next  = length_reg - HDR_LEN;
                            phase_next = PH_PAYLOAD;
                        end
                        length_next = '0;
                        id_next     = '0;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                result.kind         = KIND_PAYLOAD;
                result.payload_byte = data_byte;
                if (left_reg <= 32'd1)
                begin
                    result.last_of_packet = 1'b1;
                    left_next             = '0;
                    phase_next            = PH_HEADER;
                end
                else
                begin
                    left_next = left_reg - 32'd1;
                end
            end
            default:
            begin
                // handshake phase, also taken by unused phase codes
                mismatch_next = hs_miss;
                if (count_reg < HS_LAST)
                begin
                    count_next  = count_reg + 4'd1;
                    result.kind = KIND_PENDING;
                end
                else
                begin
                    count_next    = '0;
                    mismatch_next = 1'b0;
                    if (hs_miss)
                    begin
                        phase_next  = PH_HS_FAIL;
                        result.kind = KIND_HS_BAD;
                    end
                    else
                    begin
                        phase_next  = PH_HEADER;
                        result.kind = KIND_HS_GOOD;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HANDSHAKE;
            count_reg    <= '0;
            mismatch_reg <= 1'b0;
            length_reg   <= '0;
            id_reg       <= '0;
            flags_reg    <= '0;
            set_reg      <= '0;
            left_reg     <= '0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            mismatch_reg <= mismatch_next;
            length_reg   <= length_next;
            id_reg       <= id_next;
            flags_reg    <= flags_next;
            set_reg      <= set_next;
            left_reg     <= left_next;
        end
    end

endmodule

// ===== src/jdwp_sd_out_stage.sv =====
// ----------------------------------------------------------------------------
// jdwp_sd_out_stage
// Result register and master-side packing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdwp_sd_out_stage
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  jdwp_sd_pkg::result_t          result,
    output logic                          out_ready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [jdwp_sd_pkg::TDATA_W-1:0] m_tdata,
    output logic [2:0]                    m_tuser,
    output logic                          m_tlast
);
    import jdwp_sd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_ready  = !valid_reg || m_tready;
    assign valid_next = advance || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last_of_packet;
    assign m_tdata  = {5'b0,
                       res_reg.payload_byte,
                       res_reg.is_ddm,
                       res_reg.error_code,
                       res_reg.cmd_code,
                       res_reg.cmd_set,
                       res_reg.is_error,
                       res_reg.is_reply,
                       res_reg.packet_id,
                       res_reg.packet_length};

endmodule

// ===== src/jdwp_stream_deframer_top.sv =====
// An input byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle while the master side is not stalled; the phase/count update in jdwp_sd_parser
// sits between the input register and the result register.
// Exactly one result per input byte. Reset (rst_n low, async) empties both
// stages and returns the parser to the start of the handshake.
// ----------------------------------------------------------------------------
// jdwp_stream_deframer_top
// Byte-serial JDWP handshake checker and packet header deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdwp_stream_deframer_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] packet_length, [63:32] packet_id, [64] is_reply, [65] is_error,
    // [73:66] cmd_set, [81:74] cmd_code, [97:82] error_code, [98] is_ddm,
    // [106:99] payload_byte, [111:107] zero
    output logic [jdwp_sd_pkg::TDATA_W-1:0] m_tdata,
    output logic [2:0]                      m_tuser,   // [2:0] kind
    output logic                            m_tlast    // last_of_packet
);
    import jdwp_sd_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_ready;
    logic       advance;
    result_t    result;

    assign advance = in_valid && out_ready;

    jdwp_sd_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    jdwp_sd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (in_byte),
        .result    (result)
    );

    jdwp_sd_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .result    (result),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== src/jdwp_sd_checker.sv =====
// ----------------------------------------------------------------------------
// jdwp_sd_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "jdwp_stream_deframer_top_defines.svh"

module jdwp_sd_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [jdwp_sd_pkg::TDATA_W-1:0] m_tdata,
    input logic [2:0]                      m_tuser,
    input logic                            m_tlast
);
    import jdwp_sd_pkg::*;

    // stalled result holds
    `JDWP_SD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // last mark only on payload or empty-packet header
    `JDWP_SD_ASSERT_NOW(a_last_kind, m_tvalid && m_tlast, m_tuser == KIND_HEADER || m_tuser == KIND_PAYLOAD, "last mark on wrong kind")

    // payload byte field is zero outside payload transfers
    `JDWP_SD_ASSERT_NOW(a_payload_zero, m_tvalid && m_tuser != KIND_PAYLOAD, m_tdata[106:99] == 8'd0, "payload field not zero")

    // failures are sticky
    `JDWP_SD_ASSERT_NEXT(a_hs_sticky, m_tvalid && m_tready && m_tuser == KIND_HS_BAD, !m_tvalid || m_tuser == KIND_HS_BAD, "handshake failure not sticky")
    `JDWP_SD_ASSERT_NEXT(a_pkt_sticky, m_tvalid && m_tready && m_tuser == KIND_BAD_PKT, !m_tvalid || m_tuser == KIND_BAD_PKT, "bad packet not sticky")

endmodule

bind jdwp_stream_deframer_top jdwp_sd_checker u_checker (.*);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for jdwp_stream_deframer_top. Drives a JDWP byte stream:
// the handshake, directed command/reply packets, a long sink hold-off, random
// packets, then a packet with a short length field. A local predictor of the
// deframer state expects one result per byte, and a checker compares every
// master-side transfer against the oldest expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import jdwp_sd_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_BYTES = 520;
    localparam int HOLDOFF_LEN  = 150;
    localparam int HS_BYTES     = 14;
    localparam logic [8*HS_BYTES-1:0] HANDSHAKE_TEXT = "JDWP-Handshake";

    typedef enum logic [2:0] {
        LINK_HANDSHAKE,
        LINK_HEADER,
        LINK_PAYLOAD,
        LINK_HS_FAIL,
        LINK_PKT_FAIL
    } link_phase_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic [2:0]           m_tuser;
    logic                 m_tlast;

    // predictor state
    link_phase_t link_phase   = LINK_HANDSHAKE;
    logic [3:0]  hs_pos       = '0;
    logic [3:0]  hdr_pos      = '0;
    logic        hs_bad       = 1'b0;
    logic [31:0] len_acc      = '0;
    logic [31:0] id_acc       = '0;
    logic [7:0]  flags_q      = '0;
    logic [7:0]  set_q        = '0;
    logic [31:0] payload_left = '0;

    result_t     expected_results[$];

    bit          idle_en;
    bit          stall_en;
    int          holdoff_len;
    int unsigned cycle_count;
    int unsigned bytes_sent;
    int unsigned err_count;
    int unsigned seen_headers;
    int unsigned seen_replies;
    int unsigned seen_errors;
    int unsigned seen_ddm;
    int unsigned seen_payload;
    int unsigned seen_bad_pkt;

    result_t     got_result;
    result_t     want_result;

    jdwp_stream_deframer_top i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("testbench failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // next result of the deframer for byte b; advances the predictor state
    function automatic result_t deframe_byte(input logic [7:0] b);
        result_t     r;
        logic [3:0]  n;
        logic [15:0] err;
        r = '0;
        case (link_phase)
            LINK_HS_FAIL:  r.kind = KIND_HS_BAD;
            LINK_PKT_FAIL: r.kind = KIND_BAD_PKT;
            LINK_HEADER:
            begin
                n = hdr_pos;
                if (n < 4'd4)
                    len_acc = {len_acc[23:0], b};
                else if (n < 4'd8)
                    id_acc = {id_acc[23:0], b};
                else if (n == 4'd8)
                    flags_q = b;
                else if (n == 4'd9)
                    set_q = b;
                if (n < HDR_LAST)
                begin
                    hdr_pos = n + 4'd1;
                    r.kind  = KIND_PENDING;
                end
                else
                begin
                    hdr_pos = '0;
                    if (len_acc < HDR_LEN)
                    begin
                        link_phase = LINK_PKT_FAIL;
                        r.kind     = KIND_BAD_PKT;
                    end
                    else
                    begin
                        r.kind          = KIND_HEADER;
                        r.packet_length = len_acc;
                        r.packet_id     = id_acc;
                        if (flags_q[REPLY_BIT])
                        begin
                            err          = {b, set_q};
                            r.is_reply   = 1'b1;
                            r.is_error   = (err != 16'd0);
                            r.error_code = err;
                        end
                        else
                        begin
                            r.cmd_set  = set_q;
                            r.cmd_code = b;
                            r.is_ddm   = (set_q == DDM_SET) && (b == DDM_CMD);
                        end
                        if (len_acc == HDR_LEN)
                        begin
                            r.last_of_packet = 1'b1;
                            link_phase       = LINK_HEADER;
                        end
                        else
                        begin
                            payload_left = len_acc - HDR_LEN;
                            link_phase   = LINK_PAYLOAD;
                        end
                        len_acc = '0;
                        id_acc  = '0;
                    end
                end
            end
            LINK_PAYLOAD:
            begin
                r.kind         = KIND_PAYLOAD;
                r.payload_byte = b;
                if (payload_left <= 32'd1)
                begin
                    r.last_of_packet = 1'b1;
                    payload_left     = '0;
                    link_phase       = LINK_HEADER;
                end
                else
                    payload_left = payload_left - 32'd1;
            end
            default:
            begin
                n = hs_pos;
                if (n > HS_LAST)
                    n = HS_LAST;
                if (b != HANDSHAKE_TEXT[8*(HS_BYTES-1-n) +: 8])
                    hs_bad = 1'b1;
                if (n < HS_LAST)
                begin
                    hs_pos = n + 4'd1;
                    r.kind = KIND_PENDING;
                end
                else
                begin
                    hs_pos     = '0;
                    link_phase = hs_bad ? LINK_HS_FAIL : LINK_HEADER;
                    r.kind     = hs_bad ? KIND_HS_BAD : KIND_HS_GOOD;
                    hs_bad     = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    function automatic result_t unpack_result(input logic [TDATA_W-1:0] d,
                                              input logic [2:0] k, input logic l);
        result_t r;
        r.kind           = k;
        r.packet_length  = d[31:0];
        r.packet_id      = d[63:32];
        r.is_reply       = d[64];
        r.is_error       = d[65];
        r.cmd_set        = d[73:66];
        r.cmd_code       = d[81:74];
        r.error_code     = d[97:82];
        r.is_ddm         = d[98];
        r.payload_byte   = d[106:99];
        r.last_of_packet = l;
        return r;
    endfunction

    function automatic string show_result(input result_t r);
        return $sformatf({"kind=%0d len=%h id=%h reply=%b err=%b set=%h cmd=%h ",
                          "code=%h ddm=%b byte=%h last=%b"},
                         r.kind, r.packet_length, r.packet_id, r.is_reply,
                         r.is_error, r.cmd_set, r.cmd_code, r.error_code,
                         r.is_ddm, r.payload_byte, r.last_of_packet);
    endfunction

    task automatic log_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // result checker: one master-side transfer per edge at most
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_result = unpack_result(m_tdata, m_tuser, m_tlast);
            if (expected_results.size() == 0)
                log_mismatch({"unexpected result: ", show_result(got_result)});
            else
            begin
                want_result = expected_results.pop_front();
                if (got_result !== want_result || m_tdata[TDATA_W-1:107] !== '0)
                    log_mismatch($sformatf("mismatch pad=%h\n    exp %s\n    got %s",
                                           m_tdata[TDATA_W-1:107],
                                           show_result(want_result),
                                           show_result(got_result)));
            end
            case (got_result.kind)
                KIND_HEADER:
                begin
                    seen_headers++;
                    seen_replies += got_result.is_reply;
                    seen_errors  += got_result.is_error;
                    seen_ddm     += got_result.is_ddm;
                end
                KIND_PAYLOAD: seen_payload++;
                KIND_BAD_PKT: seen_bad_pkt++;
                default: ;
            endcase
        end
    end

    // sink side: random stalls, plus a long hold-off on request
    initial
    begin
        int n;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (holdoff_len > 0)
            begin
                m_tready <= 1'b0;
                repeat (holdoff_len) @(negedge clk);
                holdoff_len = 0;
                m_tready <= 1'b1;
            end
            else if (stall_en && $urandom_range(0, 3) == 0)
            begin
                n = pick_gap();
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int n;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(deframe_byte(b));
        bytes_sent++;
        if (idle_en && $urandom_range(0, 2) == 0)
        begin
            n = pick_gap();
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // header bytes big-endian, then (length - 11) random payload bytes if length exceeds 11
    task automatic send_packet(input logic [31:0] length, input logic [31:0] id,
                               input logic [7:0] flags, input logic [7:0] b9,
                               input logic [7:0] b10);
        int unsigned pay;
        pay = (length > HDR_LEN) ? length - HDR_LEN : 0;
        for (int i = 0; i < 4; i++)
            send_byte(length[31-8*i -: 8]);
        for (int i = 0; i < 4; i++)
            send_byte(id[31-8*i -: 8]);
        send_byte(flags);
        send_byte(b9);
        send_byte(b10);
        for (int unsigned i = 0; i < pay; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_handshake();
        idle_en  = 1'b1;
        stall_en = 1'b1;
        for (int i = 0; i < HS_BYTES; i++)
            send_byte(HANDSHAKE_TEXT[8*(HS_BYTES-1-i) +: 8]);
    endtask

    task automatic test_directed_packets();
        // empty DDM command, reply with all-ones error and payload, empty clean reply
        send_packet(HDR_LEN, 32'h0000_0000, 8'h00, DDM_SET, DDM_CMD);
        send_packet(HDR_LEN + 2, 32'hffff_ffff, 8'hff, 8'hff, 8'hff);
        send_packet(HDR_LEN, 32'h8000_0001, 8'h80, 8'h00, 8'h00);
        wait_drained();
    endtask

    task automatic test_backpressure();
        idle_en     = 1'b0;
        stall_en    = 1'b0;
        holdoff_len = HOLDOFF_LEN;
        send_packet(HDR_LEN + 60, $urandom, 8'h7f, DDM_SET, 8'h02);
        wait_drained();
    endtask

    task automatic send_random_packet();
        int unsigned pay;
        int          r;
        logic [7:0]  flags;
        logic [7:0]  b9;
        logic [7:0]  b10;
        r = $urandom_range(0, 99);
        if (r < 45)
            pay = $urandom_range(0, 3);
        else if (r < 90)
            pay = $urandom_range(4, 24);
        else
            pay = $urandom_range(25, 60);
        flags = 8'($urandom_range(0, 255));
        b9    = 8'($urandom_range(0, 255));
        b10   = 8'($urandom_range(0, 255));
        if (flags[REPLY_BIT])
        begin
            case ($urandom_range(0, 3))
                0: begin b9 = 8'h00; b10 = 8'h00; end
                1: b10 = 8'h00;
                2: b9 = 8'h00;
                default: ;
            endcase
        end
        else
        begin
            r = $urandom_range(0, 9);
            if (r < 2)
            begin
                b9  = DDM_SET;
                b10 = DDM_CMD;
            end
            else if (r == 2)
                b9 = DDM_SET;
        end
        send_packet(HDR_LEN + pay, $urandom, flags, b9, b10);
    endtask

    task automatic test_random_packets();
        while (bytes_sent < RANDOM_BYTES)
        begin
            idle_en  = $urandom_range(0, 3) != 0;
            stall_en = $urandom_range(0, 3) != 0;
            send_random_packet();
        end
        wait_drained();
    endtask

    // short length field: sticky bad-packet state for everything after it
    task automatic test_bad_length();
        idle_en  = 1'b1;
        stall_en = 1'b1;
        send_packet(32'($urandom_range(0, HDR_LEN - 1)), $urandom, 8'h00, 8'h01, 8'h02);
        repeat (12)
            send_byte(8'($urandom_range(0, 255)));
        wait_drained();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        idle_en     = 1'b0;
        stall_en    = 1'b0;
        holdoff_len = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_handshake();
        test_directed_packets();
        test_backpressure();
        test_random_packets();
        test_bad_length();

        $display("sent %0d bytes: handshake, %0d headers (%0d replies, %0d with error, %0d DDM),",
                 bytes_sent, seen_headers, seen_replies, seen_errors, seen_ddm);
        $display("%0d payload bytes, %0d bad-packet results after a short length, %0d mismatches",
                 seen_payload, seen_bad_pkt, err_count);
        if (err_count == 0 && expected_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
